@@ hdl/wfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_pkg: shared types and constants of the windowed FNV-1a checksum
// Transfer structs of both queue sides, the internal operation word passed
// from front to back, register indexes and the FNV step function.
// ----------------------------------------------------------------------------
package wfc_pkg;

  localparam logic [31:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [31:0] FnvPrime = 32'h0100_0193;
  localparam logic [15:0] HeadReset = 16'd4096;
  localparam logic [7:0]  TailReset = 8'd64;
  localparam int unsigned LenShift = 16;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgHeadWindow = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTailWindow = 1'b1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [31:0] blob_length;
    logic        first_item;
    logic        last_item;
    logic        empty_blob;
  } in_item_t;

  typedef struct packed {
    logic [31:0] checksum;
    logic        length_error;
  } out_item_t;

  // Operation word from the front end to the hash engine
  typedef struct packed {
    logic        fresh;     // start from the offset basis
    logic        do_byte;   // fold data into the hash
    logic [7:0]  data;
    logic        finish;    // mix in length and deliver a result
    logic [31:0] length;
    logic        err;
  } op_t;

  typedef enum logic [1:0] {
    BkRun,
    BkMix1,
    BkMix2
  } bk_state_e;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] x;
    x = h ^ v;
    return x * FnvPrime;
  endfunction

endpackage

@@ hdl/windowed_fnv1a_blob_checksum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_fnv1a_blob_checksum: windowed FNV-1a blob checksum
// Hashes head and tail window bytes of each blob, mixes in the length and
// gives one checksum with a length mismatch flag per blob.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the engine is not mixing a length and
//   the result side is not stalled; each blob end adds two length mix steps.
// Result path: a last or empty item passes the queue, the byte step and two
//   length steps on its way to the result side.
// Reset: asynchronous, clears queues and blob state; windows return to 4096
//   and 64, no clearing pass.
module windowed_fnv1a_blob_checksum import wfc_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o
);

  logic accept;
  op_t  front_op, back_op;
  logic q_valid, q_pop, res_valid;

  assign accept = push && !full;
  assign empty  = !res_valid;

  // Classify incoming items
  wfc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .accept_i  (accept),
    .item_i    (in_item_i),
    .op_o      (front_op)
  );

  // Buffer operations between front and engine
  wfc_queue #(
    .QDepth(QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .op_i   (front_op),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .op_o   (back_op)
  );

  // Run the hash engine
  wfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (q_valid),
    .op_i       (back_op),
    .op_pop_o   (q_pop),
    .res_valid_o(res_valid),
    .res_o      (out_item_o),
    .res_pop_i  (pop && res_valid)
  );

endmodule

@@ hdl/wfc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_front: item classifier
// Holds the window registers, byte position and declared length, decides per
// byte whether it falls in a window and builds the operation word.
// ----------------------------------------------------------------------------
module wfc_front import wfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                accept_i,
  input  in_item_t            item_i,
  output op_t                 op_o
);

  logic [15:0] head_q;
  logic [7:0]  tail_q;
  logic [31:0] pos_q, pos_d;
  logic [31:0] held_q, held_d;

  logic [32:0] diff;
  logic [31:0] tail_start;
  logic        win_first, win_cont, in_win;
  logic [31:0] len_eff, pos_eff;
  logic        blob_err;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HeadReset;
      tail_q <= TailReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeadWindow: head_q <= cfg_data_i;
        CfgTailWindow: tail_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Tail window start from the held length
  always_comb begin
    diff = {1'b0, held_q} - {25'd0, tail_q};
    if (!diff[32] && (diff[31:0] > {16'd0, head_q})) begin
      tail_start = diff[31:0];
    end else begin
      tail_start = {16'd0, head_q};
    end
  end

  // Classify the byte and build the operation
  always_comb begin
    win_first = (head_q != 16'd0) || (item_i.blob_length <= {24'd0, tail_q});
    win_cont  = (pos_q < {16'd0, head_q}) || (pos_q >= tail_start);
    in_win    = item_i.first_item ? win_first : win_cont;
    len_eff   = item_i.first_item ? item_i.blob_length : held_q;
    pos_eff   = item_i.first_item ? 32'd0 : pos_q;
    blob_err  = (len_eff == 32'd0) || (pos_eff != (len_eff - 32'd1));

    op_o.fresh   = item_i.first_item || item_i.empty_blob;
    op_o.do_byte = !item_i.empty_blob && in_win;
    op_o.data    = item_i.data_byte;
    op_o.finish  = item_i.last_item || item_i.empty_blob;
    op_o.length  = item_i.empty_blob ? item_i.blob_length : len_eff;
    op_o.err     = item_i.empty_blob ? (item_i.blob_length != 32'd0) : blob_err;

    // Advance position, saturate, clear at the end of a blob
    if (op_o.finish) begin
      pos_d = 32'd0;
    end else if (pos_eff == 32'hFFFF_FFFF) begin
      pos_d = pos_eff;
    end else begin
      pos_d = pos_eff + 32'd1;
    end
    held_d = (item_i.first_item || item_i.empty_blob) ? item_i.blob_length : held_q;
  end

  // Update blob tracking on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 32'd0;
      held_q <= 32'd0;
    end else if (accept_i) begin
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

endmodule

@@ hdl/wfc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_queue: operation queue
// Short first-in first-out buffer between the classifier and the hash engine.
// ----------------------------------------------------------------------------
module wfc_queue import wfc_pkg::*; #(
  parameter int unsigned QDepth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

  op_t             mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Store pushed operations
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= op_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ hdl/wfc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_back: hash engine
// Folds one operation per cycle into the running FNV-1a hash in BkRun; at a
// blob end mixes in the length (BkMix1, BkMix2) and loads the result register.
// ----------------------------------------------------------------------------
module wfc_back import wfc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  output logic      res_valid_o,
  output out_item_t res_o,
  input  logic      res_pop_i
);

  bk_state_e   state_q, state_d;
  logic [31:0] hash_q, hash_d;
  logic [31:0] len_q;
  logic        err_q;
  logic        res_valid_q, res_valid_d;
  out_item_t   res_q;
  logic        res_free, res_load;
  logic [31:0] h_base, step_h, step_v, step_r;

  assign res_free    = !res_valid_q || res_pop_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Shared FNV step
  assign step_r = fnv_step(step_h, step_v);

  // Next state, hash and handshakes
  always_comb begin
    state_d  = state_q;
    hash_d   = hash_q;
    op_pop_o = 1'b0;
    res_load = 1'b0;
    h_base   = op_i.fresh ? FnvBasis : hash_q;
    step_h   = h_base;
    step_v   = {24'd0, op_i.data};
    unique case (state_q)
      BkRun: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          hash_d   = op_i.do_byte ? step_r : h_base;
          if (op_i.finish) begin
            state_d = BkMix1;
          end
        end
      end
      BkMix1: begin
        step_h  = hash_q;
        step_v  = len_q;
        hash_d  = step_r;
        state_d = BkMix2;
      end
      BkMix2: begin
        step_h = hash_q;
        step_v = len_q >> LenShift;
        if (res_free) begin
          res_load = 1'b1;
          hash_d   = FnvBasis;
          state_d  = BkRun;
        end
      end
      default: state_d = BkRun;
    endcase
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkRun;
      hash_q      <= FnvBasis;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Capture blob end data and the result
  always_ff @(posedge clk_i) begin
    if (op_pop_o && op_i.finish) begin
      len_q <= op_i.length;
      err_q <= op_i.err;
    end
    if (res_load) begin
      res_q.checksum     <= step_r;
      res_q.length_error <= err_q;
    end
  end

`ifndef SYNTHESIS
  a_mix_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BkMix1 |=> state_q == BkMix2)
    else $error("length mix steps out of order");

  a_pop_only_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_pop_o |-> (state_q == BkRun && op_valid_i))
    else $error("operation taken while mixing length");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BkMix2 && res_free) |=> (res_valid_q && hash_q == FnvBasis))
    else $error("result not loaded at blob end");
`endif

endmodule

@@ bench/blob_checksum_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_checksum_checker: result checker for the windowed FNV-1a checksum
// Watches the input, result and register ports of the block. Keeps its own
// copy of the window registers and blob state, works out the checksum and
// length flag each accepted item should give, and compares every result
// transfer with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module blob_checksum_checker import wfc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                push_i,
  input  logic                full_i,
  input  in_item_t            in_item_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  out_item_t           out_item_i,
  output int                  waiting_o,
  output int                  errors_o
);

  localparam logic [31:0] OffsetBasis = 32'h811C_9DC5;
  localparam logic [31:0] HashPrime   = 32'h0100_0193;
  localparam logic [15:0] HeadDefault = 16'd4096;
  localparam logic [7:0]  TailDefault = 8'd64;

  // Window registers and blob state as the block should hold them
  logic [15:0] head_win;
  logic [7:0]  tail_win;
  logic [31:0] run_hash;
  logic [31:0] byte_pos;
  logic [31:0] held_len;

  out_item_t expected_sums[$];
  int        mismatches;

  assign errors_o = mismatches;

  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [31:0] v);
    logic [31:0] mixed;
    mixed = h ^ v;
    return mixed * HashPrime;
  endfunction

  // Length goes in as two steps: whole value, then its upper half
  function automatic logic [31:0] fold_length(input logic [31:0] h, input logic [31:0] len);
    logic [31:0] acc;
    acc = fnv_fold(h, len);
    return fnv_fold(acc, len >> 16);
  endfunction

  // Advance the blob state by one item, queue a checksum if it ends a blob
  task automatic absorb_item(input in_item_t it);
    logic [31:0] tail_start;
    logic [31:0] pos;
    out_item_t   sum;
    if (it.empty_blob) begin
      // whole zero-length blob: drop anything in progress
      held_len         = it.blob_length;
      sum.checksum     = fold_length(OffsetBasis, it.blob_length);
      sum.length_error = (it.blob_length != 32'd0);
      expected_sums.insert(expected_sums.size(), sum);
      run_hash = OffsetBasis;
      byte_pos = 32'd0;
    end else begin
      if (it.first_item) begin
        held_len = it.blob_length;
        run_hash = OffsetBasis;
        byte_pos = 32'd0;
      end
      // tail window never starts inside the head window
      if (held_len >= {24'd0, tail_win} && held_len - {24'd0, tail_win} > {16'd0, head_win}) begin
        tail_start = held_len - {24'd0, tail_win};
      end else begin
        tail_start = {16'd0, head_win};
      end
      pos = byte_pos;
      if (pos < {16'd0, head_win} || pos >= tail_start) begin
        run_hash = fnv_fold(run_hash, {24'd0, it.data_byte});
      end
      if (byte_pos != 32'hFFFF_FFFF) begin
        byte_pos = byte_pos + 32'd1;
      end
      if (it.last_item) begin
        sum.checksum     = fold_length(run_hash, held_len);
        sum.length_error = (held_len == 32'd0) || (pos != held_len - 32'd1);
        expected_sums.insert(expected_sums.size(), sum);
        run_hash = OffsetBasis;
        byte_pos = 32'd0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      head_win   = HeadDefault;
      tail_win   = TailDefault;
      run_hash   = OffsetBasis;
      byte_pos   = 32'd0;
      held_len   = 32'd0;
      mismatches = 0;
      expected_sums.delete();
      waiting_o <= 0;
    end else begin
      // compare a result transfer with the oldest expectation
      if (pop_i && !empty_i) begin
        if (expected_sums.size() == 0) begin
          mismatches++;
          $display("%0t: result with no checksum expected: got %h / %b",
                   $time, out_item_i.checksum, out_item_i.length_error);
        end else begin
          want = expected_sums.pop_front();
          if (out_item_i.checksum !== want.checksum) begin
            mismatches++;
            $display("%0t: checksum mismatch: expected %h, got %h",
                     $time, want.checksum, out_item_i.checksum);
          end
          if (out_item_i.length_error !== want.length_error) begin
            mismatches++;
            $display("%0t: length flag mismatch: expected %b, got %b",
                     $time, want.length_error, out_item_i.length_error);
          end
        end
      end
      // predict from an input transfer
      if (push_i && !full_i) begin
        absorb_item(in_item_i);
      end
      // track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeadWindow: begin
            head_win = cfg_data_i[15:0];
          end
          CfgTailWindow: begin
            tail_win = cfg_data_i[7:0];
          end
          default: begin
          end
        endcase
      end
      waiting_o <= expected_sums.size();
    end
  end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for windowed_fnv1a_blob_checksum
// Runs a directed set of blobs at the reset windows, then random phases of
// well-formed, truncated, overlong, dropped and empty blobs under several
// window settings, with random idling on both queue sides. Checking is done
// by blob_checksum_checker beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import wfc_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 90;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                push;
  logic                full;
  in_item_t            in_item;
  logic                empty;
  logic                pop;
  out_item_t           out_item;
  int                  sums_waiting;
  int                  mismatches;

  int items_sent = 0;
  int send_mode  = 0;
  int cur_head   = 4096;
  int cur_tail   = 64;
  int cycles     = 0;

  windowed_fnv1a_blob_checksum dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  blob_checksum_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push_i     (push),
    .full_i     (full),
    .in_item_i  (in_item),
    .empty_i    (empty),
    .pop_i      (pop),
    .out_item_i (out_item),
    .waiting_o  (sums_waiting),
    .errors_o   (mismatches)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Idle cycles before a transfer: none, a uniform random draw, or mostly none
  function automatic int draw_idle(input int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic in_item_t byte_item(input logic [7:0] data, input logic [31:0] len,
                                         input logic first, input logic last,
                                         input logic blank);
    in_item_t it;
    it.data_byte   = data;
    it.blob_length = len;
    it.first_item  = first;
    it.last_item   = last;
    it.empty_blob  = blank;
    return it;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_item(input in_item_t it);
    int gap;
    gap = draw_idle(send_mode);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    if ($urandom_range(0, 47) == 0) begin
      send_mode = $urandom_range(0, 2);
    end
  endtask

  // Send n bytes; blob_length only matters on the first item
  task automatic send_blob(input logic [31:0] declared, input int n,
                           input bit with_first, input bit with_last);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it = byte_item(8'($urandom), (i == 0) ? declared : 32'($urandom),
                     with_first && (i == 0), with_last && (i == n - 1), 1'b0);
      send_item(it);
    end
  endtask

  // Hold off the sender until every checksum is back and the block is quiet
  task automatic settle_results();
    push <= 1'b0;
    @(posedge clk);
    while (sums_waiting != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_windows(input logic [15:0] head, input logic [7:0] tail);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgHeadWindow;
    cfg_data <= head;
    @(posedge clk);
    cfg_idx  <= CfgTailWindow;
    cfg_data <= {junk, tail};
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_head = int'(head);
    cur_tail = int'(tail);
  endtask

  // Blob sizes that straddle the current head and tail windows
  function automatic int pick_len();
    int span;
    span = cur_head + cur_tail + 6;
    if (span > 40) span = 40;
    if ($urandom_range(0, 9) == 0) span = 80;
    return $urandom_range(1, span);
  endfunction

  task automatic random_phase(input int target);
    int          kind;
    int          n;
    logic [31:0] declared;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      n    = pick_len();
      if (kind < 70) begin
        send_blob(n, n, 1'b1, 1'b1);
      end else if (kind < 80) begin
        // declared length disagrees with the bytes sent
        case ($urandom_range(0, 3))
          0: declared = n + 1;
          1: declared = n - 1;
          2: declared = 32'd0;
          default: declared = $urandom;
        endcase
        send_blob(declared, n, 1'b1, 1'b1);
      end else if (kind < 88) begin
        declared = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
        send_item(byte_item(8'($urandom), declared, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'b1));
      end else if (kind < 93) begin
        // abandon a blob part way; the next first item restarts
        send_blob(n, $urandom_range(1, n), 1'b1, 1'b0);
      end else if (kind < 96) begin
        send_blob($urandom, n, 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(byte_item(8'($urandom), 32'($urandom), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'b0));
        end
      end
    end
  endtask

  // Result side: pop with random stalls, forever
  initial begin : result_sink
    int stall;
    int mode;
    mode = 0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_idle(mode);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      if ($urandom_range(0, 47) == 0) begin
        mode = $urandom_range(0, 2);
      end
    end
  end

  initial begin : stimulus
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = CfgHeadWindow;
    cfg_data = '0;
    push     = 1'b0;
    pop      = 1'b0;
    in_item  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed blobs at the reset windows
    send_item(byte_item(8'hFF, 32'd0, 1'b1, 1'b1, 1'b1));
    send_item(byte_item(8'h00, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1));
    send_item(byte_item(8'h00, 32'd1, 1'b1, 1'b1, 1'b0));
    send_item(byte_item(8'hFF, 32'd0, 1'b1, 1'b1, 1'b0));
    send_item(byte_item(8'hA5, 32'd3, 1'b1, 1'b0, 1'b0));
    send_item(byte_item(8'h5A, 32'h0, 1'b0, 1'b0, 1'b0));
    send_item(byte_item(8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0));
    // last item with no first: continues with the kept length
    send_item(byte_item(8'h3C, 32'h1234_5678, 1'b0, 1'b1, 1'b0));
    // restart inside a blob
    send_item(byte_item(8'h11, 32'd5, 1'b1, 1'b0, 1'b0));
    send_item(byte_item(8'h22, 32'd0, 1'b0, 1'b0, 1'b0));
    send_item(byte_item(8'h33, 32'd2, 1'b1, 1'b0, 1'b0));
    send_item(byte_item(8'h44, 32'd0, 1'b0, 1'b1, 1'b0));
    // more bytes than declared, then fewer
    send_blob(32'd2, 4, 1'b1, 1'b1);
    send_blob(32'd4, 2, 1'b1, 1'b1);
    // empty item in the middle of a blob drops it
    send_item(byte_item(8'h81, 32'd3, 1'b1, 1'b0, 1'b0));
    send_item(byte_item(8'h7E, 32'd7, 1'b0, 1'b0, 1'b1));
    send_item(byte_item(8'h18, 32'd9, 1'b0, 1'b1, 1'b0));
    send_blob(32'hFFFF_FFFF, 2, 1'b1, 1'b1);
    send_blob(32'h8000_0000, 1, 1'b1, 1'b1);

    random_phase(items_sent + PhaseItems);
    settle_results();

    // Random phases over a range of window settings
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: write_windows(16'd0, 8'd0);
        1: write_windows(16'hFFFF, 8'hFF);
        2: write_windows(16'd2, 8'd3);
        3: write_windows(16'd0, 8'hFF);
        4: write_windows(16'hFFFF, 8'd0);
        5: write_windows(16'd5, 8'd2);
        6: write_windows(16'd1, 8'd1);
        7: write_windows(16'd0, 8'd6);
        8: write_windows(16'($urandom_range(0, 12)), 8'($urandom_range(0, 12)));
        default: write_windows(16'($urandom), 8'($urandom));
      endcase
      if (ph == 5) begin
        // stop mid-phase until the block has caught up
        random_phase(items_sent + PhaseItems / 2);
        settle_results();
      end
      random_phase(items_sent + PhaseItems);
      settle_results();
    end

    if (mismatches == 0 && sums_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/wfc_pkg.sv
hdl/wfc_front.sv
hdl/wfc_queue.sv
hdl/wfc_back.sv
hdl/windowed_fnv1a_blob_checksum.sv
bench/blob_checksum_checker.sv
bench/testbench.sv
